/* rtl/core/rtyuv_pkg.sv */
// ----------------------------------------------------------------------------
// rtyuv_pkg: shared types and constants for the RGB to YUV subsampler
// Coefficients, mode codes, register indexes and the item that moves
// from the classifying front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package rtyuv_pkg;

    // Line geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = $clog2(LINE_DEPTH);
    localparam int WIDTH_W    = 11;

    // Pixel and sum widths
    localparam int PIX_W  = 8;
    localparam int PAIR_W = PIX_W + 1;
    localparam int SUM_W  = PIX_W + 2;
    localparam int LINE_W = 3 * PAIR_W;

    // Item queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Configuration register indexes
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    // Subsampling modes
    localparam logic [1:0] MODE_444 = 2'd0;
    localparam logic [1:0] MODE_422 = 2'd1;
    localparam logic [1:0] MODE_420 = 2'd2;

    // Q15 luma weights (unsigned)
    localparam logic [14:0] KY_R = 15'd9798;
    localparam logic [14:0] KY_G = 15'd19235;
    localparam logic [14:0] KY_B = 15'd3736;

    // Q15 chroma weights (signed)
    localparam logic signed [15:0] KU_R = -16'sd4821;
    localparam logic signed [15:0] KU_G = -16'sd9465;
    localparam logic signed [15:0] KU_B = 16'sd14287;
    localparam logic signed [15:0] KV_R = 16'sd20152;
    localparam logic signed [15:0] KV_G = -16'sd16875;
    localparam logic signed [15:0] KV_B = -16'sd3277;

    // Chroma group size: sets the final shift (15, 16 or 17)
    typedef enum logic [1:0] {
        GRP_ONE  = 2'd0,
        GRP_PAIR = 2'd1,
        GRP_QUAD = 2'd2
    } t_grp;

    // One classified pixel
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             chroma;
        t_grp             grp;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
    } t_item;

endpackage

/* rtl/core/rgb_to_yuv_subsampler.sv */
// ----------------------------------------------------------------------------
// rgb_to_yuv_subsampler: BT.601 RGB to YUV with 444, 422 or 420 chroma
// Raster-order RGB pixels in, one luma per pixel plus U and V whenever a
// pixel closes a chroma group (every pixel, odd columns, or odd columns of
// odd rows). A new pixel is taken every clock unless a full queue holds the
// front-end stage; a pixel's result passes one front-end stage, the queue,
// then the product and sum stages and the output register. The 420 mode keeps
// one line of pair sums in a single-port line store, one write or read per
// pixel pair.
// The line store is not cleared: a 420 odd row must follow its even row.
// Configuration writes (mode, line width) are taken at any time but must
// only be issued while no pixel is in flight.
// ----------------------------------------------------------------------------
module rgb_to_yuv_subsampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic                          i_frame_start,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_luma,
    output logic                          o_chroma_valid,
    output logic signed [7:0]             o_u_chroma,
    output logic signed [7:0]             o_v_chroma,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [rtyuv_pkg::WIDTH_W-1:0] i_cfg_data
);

    logic [1:0]                    r_mode;
    logic [rtyuv_pkg::WIDTH_W-1:0] r_width;

    logic             f_valid, f_ready;
    rtyuv_pkg::t_item f_item;
    logic             q_valid, q_ready;
    rtyuv_pkg::t_item q_item;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= rtyuv_pkg::MODE_444;
            r_width <= rtyuv_pkg::WIDTH_W'(rtyuv_pkg::MAX_WIDTH);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rtyuv_pkg::REG_MODE:  r_mode  <= i_cfg_data[1:0];
                rtyuv_pkg::REG_WIDTH: r_width <= i_cfg_data;
                default:              r_mode  <= r_mode;
            endcase
        end
    end

    // Front end: position tracking and grouping
    rtyuv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_frame_start(i_frame_start),
        .i_mode       (r_mode),
        .i_width      (r_width),
        .o_item_valid (f_valid),
        .i_item_ready (f_ready),
        .o_item       (f_item)
    );

    // Decoupling queue
    rtyuv_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(f_valid),
        .o_ready(f_ready),
        .i_item (f_item),
        .o_valid(q_valid),
        .i_ready(q_ready),
        .o_item (q_item)
    );

    // Back end: arithmetic
    rtyuv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .o_ready       (q_ready),
        .i_item        (q_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_luma        (o_luma),
        .o_chroma_valid(o_chroma_valid),
        .o_u_chroma    (o_u_chroma),
        .o_v_chroma    (o_v_chroma)
    );

endmodule

/* rtl/core/rtyuv_front.sv */
// ----------------------------------------------------------------------------
// rtyuv_front: pixel intake and chroma group classification
// Tracks column and row, holds the even pixel of each pair, keeps the
// pair-sum line store for 420 and forms the channel sums of each group.
// ----------------------------------------------------------------------------
module rtyuv_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rtyuv_pkg::PIX_W-1:0]   i_red,
    input  logic [rtyuv_pkg::PIX_W-1:0]   i_green,
    input  logic [rtyuv_pkg::PIX_W-1:0]   i_blue,
    input  logic                          i_frame_start,
    input  logic [1:0]                    i_mode,
    input  logic [rtyuv_pkg::WIDTH_W-1:0] i_width,
    output logic                          o_item_valid,
    input  logic                          i_item_ready,
    output rtyuv_pkg::t_item              o_item
);

    // Position state
    logic [rtyuv_pkg::COL_W-1:0]  r_col, n_col;
    logic                         r_row, n_row;
    logic [3*rtyuv_pkg::PIX_W-1:0] r_held, n_held;

    // Stage register
    logic                          r_s1_valid;
    logic [rtyuv_pkg::PIX_W-1:0]   r_s1_red, r_s1_green, r_s1_blue;
    logic                          r_s1_chroma;
    rtyuv_pkg::t_grp               r_s1_grp;
    logic                          r_s1_quad;
    logic [rtyuv_pkg::PAIR_W-1:0]  r_s1_sr, r_s1_sg, r_s1_sb;

    // Line store of pair sums
    logic [rtyuv_pkg::LINE_W-1:0] r_line [rtyuv_pkg::LINE_DEPTH];
    logic [rtyuv_pkg::LINE_W-1:0] r_line_q;

    logic                          accept;
    logic [rtyuv_pkg::COL_W-1:0]   cur_col;
    logic                          cur_row;
    logic [rtyuv_pkg::WIDTH_W-1:0] w_even, eff_w;
    logic [rtyuv_pkg::COL_W:0]     col_inc;
    logic [rtyuv_pkg::PAIR_W-1:0]  pr, pg, pb;
    logic [rtyuv_pkg::PAIR_W-1:0]  sr, sg, sb;
    logic                          is_420;
    logic                          chroma, line_wr, line_rd;
    rtyuv_pkg::t_grp               grp;
    logic [rtyuv_pkg::SLOT_W-1:0]  slot;

    assign o_ready = !r_s1_valid || i_item_ready;
    assign accept  = i_valid && o_ready;

    // Effective width: even, clamped to 2..MAX_WIDTH
    always_comb begin
        w_even = {i_width[rtyuv_pkg::WIDTH_W-1:1], 1'b0};
        if (w_even < rtyuv_pkg::WIDTH_W'(2)) begin
            eff_w = rtyuv_pkg::WIDTH_W'(2);
        end else if (w_even > rtyuv_pkg::WIDTH_W'(rtyuv_pkg::MAX_WIDTH)) begin
            eff_w = rtyuv_pkg::WIDTH_W'(rtyuv_pkg::MAX_WIDTH);
        end else begin
            eff_w = w_even;
        end
    end

    // Position of this pixel, with frame start clearing it
    assign cur_col = i_frame_start ? '0 : r_col;
    assign cur_row = i_frame_start ? 1'b0 : r_row;
    assign col_inc = {1'b0, cur_col} + 1'b1;
    assign slot    = cur_col[rtyuv_pkg::COL_W-1:1];
    assign is_420  = (i_mode != rtyuv_pkg::MODE_444) && (i_mode != rtyuv_pkg::MODE_422);

    // Pair sums with the held even pixel
    assign pr = {1'b0, i_red}   + {1'b0, r_held[7:0]};
    assign pg = {1'b0, i_green} + {1'b0, r_held[15:8]};
    assign pb = {1'b0, i_blue}  + {1'b0, r_held[23:16]};

    // Classify the pixel
    always_comb begin
        chroma  = 1'b0;
        line_wr = 1'b0;
        line_rd = 1'b0;
        grp     = rtyuv_pkg::GRP_ONE;
        sr      = {1'b0, i_red};
        sg      = {1'b0, i_green};
        sb      = {1'b0, i_blue};
        n_held  = r_held;
        if (i_mode == rtyuv_pkg::MODE_444) begin
            chroma = 1'b1;
        end else if (!cur_col[0]) begin
            n_held = {i_blue, i_green, i_red};
        end else begin
            sr = pr;
            sg = pg;
            sb = pb;
            if (!is_420) begin
                chroma = 1'b1;
                grp    = rtyuv_pkg::GRP_PAIR;
            end else if (!cur_row) begin
                line_wr = 1'b1;
            end else begin
                chroma  = 1'b1;
                line_rd = 1'b1;
                grp     = rtyuv_pkg::GRP_QUAD;
            end
        end
    end

    // Column advance and line wrap
    always_comb begin
        if (rtyuv_pkg::WIDTH_W'(col_inc) >= eff_w) begin
            n_col = '0;
            n_row = !cur_row;
        end else begin
            n_col = col_inc[rtyuv_pkg::COL_W-1:0];
            n_row = cur_row;
        end
    end

    // Position and held pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= 1'b0;
            r_held <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_held <= n_held;
        end
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_red    <= i_red;
            r_s1_green  <= i_green;
            r_s1_blue   <= i_blue;
            r_s1_chroma <= chroma;
            r_s1_grp    <= grp;
            r_s1_quad   <= line_rd;
            r_s1_sr     <= sr;
            r_s1_sg     <= sg;
            r_s1_sb     <= sb;
        end
    end

    // Line store: one write or one registered read per beat
    always_ff @(posedge i_clk) begin
        if (accept && line_wr) begin
            r_line[slot] <= {pb, pg, pr};
        end
        if (accept && line_rd) begin
            r_line_q <= r_line[slot];
        end
    end

    // Item toward the queue, adding the upper row pair for 420
    always_comb begin
        o_item.red    = r_s1_red;
        o_item.green  = r_s1_green;
        o_item.blue   = r_s1_blue;
        o_item.chroma = r_s1_chroma;
        o_item.grp    = r_s1_grp;
        o_item.sum_r  = {1'b0, r_s1_sr};
        o_item.sum_g  = {1'b0, r_s1_sg};
        o_item.sum_b  = {1'b0, r_s1_sb};
        if (r_s1_quad) begin
            o_item.sum_r = {1'b0, r_s1_sr} + {1'b0, r_line_q[8:0]};
            o_item.sum_g = {1'b0, r_s1_sg} + {1'b0, r_line_q[17:9]};
            o_item.sum_b = {1'b0, r_s1_sb} + {1'b0, r_line_q[26:18]};
        end
    end

    assign o_item_valid = r_s1_valid;

endmodule

/* rtl/core/rtyuv_queue.sv */
// ----------------------------------------------------------------------------
// rtyuv_queue: short item queue between front end and back end
// Circular buffer with a fill count; lets either side stall on its own.
// ----------------------------------------------------------------------------
module rtyuv_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rtyuv_pkg::t_item i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output rtyuv_pkg::t_item o_item
);

    rtyuv_pkg::t_item                r_buf [rtyuv_pkg::Q_DEPTH];
    logic [rtyuv_pkg::Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [rtyuv_pkg::Q_PTR_W:0]     r_count;
    logic                            push, pop;

    assign o_ready = r_count != (rtyuv_pkg::Q_PTR_W+1)'(rtyuv_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_buf[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/core/rtyuv_back.sv */
// ----------------------------------------------------------------------------
// rtyuv_back: luma and chroma arithmetic
// Three stages: constant products, weighted sums, then shift, truncation
// toward zero and saturation into the output register.
// ----------------------------------------------------------------------------
module rtyuv_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  rtyuv_pkg::t_item            i_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rtyuv_pkg::PIX_W-1:0] o_luma,
    output logic                        o_chroma_valid,
    output logic signed [7:0]           o_u_chroma,
    output logic signed [7:0]           o_v_chroma
);

    // Truncate toward zero after the group shift, saturate to int8
    function automatic logic signed [7:0] chroma_fix(logic signed [27:0] acc,
                                                     rtyuv_pkg::t_grp grp);
        logic        neg;
        logic [27:0] mag;
        logic [12:0] q;
        begin
            neg = acc[27];
            mag = neg ? 28'(-acc) : 28'(acc);
            unique case (grp)
                rtyuv_pkg::GRP_ONE:  q = mag[27:15];
                rtyuv_pkg::GRP_PAIR: q = {1'b0, mag[27:16]};
                rtyuv_pkg::GRP_QUAD: q = {2'b0, mag[27:17]};
                default:             q = mag[27:15];
            endcase
            if (neg) begin
                chroma_fix = (q >= 13'd128) ? -8'sd128 : 8'(-q);
            end else begin
                chroma_fix = (q > 13'd127) ? 8'sd127 : 8'(q);
            end
        end
    endfunction

    logic en;

    // Product stage
    logic                     r_p_valid;
    logic                     r_p_chroma;
    rtyuv_pkg::t_grp          r_p_grp;
    logic [22:0]              r_py_r, r_py_g, r_py_b;
    logic signed [26:0]       r_pu_r, r_pu_g, r_pu_b;
    logic signed [26:0]       r_pv_r, r_pv_g, r_pv_b;

    // Sum stage
    logic                     r_s_valid;
    logic                     r_s_chroma;
    rtyuv_pkg::t_grp          r_s_grp;
    logic [23:0]              r_sy;
    logic signed [27:0]       r_su, r_sv;

    // Output register
    logic                     r_o_valid;
    logic [rtyuv_pkg::PIX_W-1:0] r_luma;
    logic                     r_chroma;
    logic signed [7:0]        r_u, r_v;

    logic signed [10:0]       xr, xg, xb;

    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;

    assign xr = $signed({1'b0, i_item.sum_r});
    assign xg = $signed({1'b0, i_item.sum_g});
    assign xb = $signed({1'b0, i_item.sum_b});

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= i_valid;
            r_s_valid <= r_p_valid;
            r_o_valid <= r_s_valid;
        end
    end

    // Constant products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_chroma <= i_item.chroma;
            r_p_grp    <= i_item.grp;
            r_py_r     <= rtyuv_pkg::KY_R * i_item.red;
            r_py_g     <= rtyuv_pkg::KY_G * i_item.green;
            r_py_b     <= rtyuv_pkg::KY_B * i_item.blue;
            r_pu_r     <= rtyuv_pkg::KU_R * xr;
            r_pu_g     <= rtyuv_pkg::KU_G * xg;
            r_pu_b     <= rtyuv_pkg::KU_B * xb;
            r_pv_r     <= rtyuv_pkg::KV_R * xr;
            r_pv_g     <= rtyuv_pkg::KV_G * xg;
            r_pv_b     <= rtyuv_pkg::KV_B * xb;
        end
    end

    // Weighted sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_chroma <= r_p_chroma;
            r_s_grp    <= r_p_grp;
            r_sy       <= {1'b0, r_py_r} + {1'b0, r_py_g} + {1'b0, r_py_b};
            r_su       <= 28'(r_pu_r) + 28'(r_pu_g) + 28'(r_pu_b);
            r_sv       <= 28'(r_pv_r) + 28'(r_pv_g) + 28'(r_pv_b);
        end
    end

    // Final scaling into the output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_luma   <= r_sy[23] ? 8'd255 : r_sy[22:15];
            r_chroma <= r_s_chroma;
            r_u      <= r_s_chroma ? chroma_fix(r_su, r_s_grp) : 8'sd0;
            r_v      <= r_s_chroma ? chroma_fix(r_sv, r_s_grp) : 8'sd0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_luma         = r_luma;
    assign o_chroma_valid = r_chroma;
    assign o_u_chroma     = r_u;
    assign o_v_chroma     = r_v;

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for rgb_to_yuv_subsampler
// A directed table covers the color extremes, every subsampling mode, odd and
// out-of-range line widths and a width cut mid-line. Random phases then vary
// mode and width and stream pixels with random gaps on both sides. Every
// result beat is compared with a typed row's beat, else a cycle-free software copy.
// ----------------------------------------------------------------------------
module tb;

    // Q15 weights of the conversion
    localparam int LUMA_R = 9798;
    localparam int LUMA_G = 19235;
    localparam int LUMA_B = 3736;
    localparam int U_R = -4821;
    localparam int U_G = -9465;
    localparam int U_B = 14287;
    localparam int V_R = 20152;
    localparam int V_G = -16875;
    localparam int V_B = -3277;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_PIXELS = 575;
    localparam int QUIET_TAIL    = 100;
    localparam int DRAIN_CYCLES  = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int LIMIT_CYCLES  = 200000;

    typedef struct packed {
        logic [7:0]        luma;
        logic              chroma_valid;
        logic signed [7:0] u;
        logic signed [7:0] v;
    } t_yuv;

    typedef enum logic {
        ROW_PIXEL,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic                          reg_idx;
        logic [rtyuv_pkg::WIDTH_W-1:0] reg_data;
        logic [7:0]                    red;
        logic [7:0]                    green;
        logic [7:0]                    blue;
        logic                          frame_start;
        logic                          typed;
        t_yuv                          want;
    } t_row;

    localparam t_yuv NONE = '{8'd0, 1'b0, 8'sd0, 8'sd0};
    localparam int PLAN_ROWS = 33;

    // Directed table; typed rows carry their expected beat
    localparam t_row PLAN [PLAN_ROWS] = '{
        // full chroma after reset: black, white, primaries
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1,
          '{8'd0, 1'b1, 8'sd0, 8'sd0}},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1,
          '{8'd255, 1'b1, 8'sd0, 8'sd0}},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b1,
          '{8'd76, 1'b1, -8'sd37, 8'sd127}},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b1,
          '{8'd149, 1'b1, -8'sd73, -8'sd128}},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b1,
          '{8'd29, 1'b1, 8'sd111, -8'sd25}},
        // 422 on a 4-pixel line
        '{ROW_WRITE, rtyuv_pkg::REG_WIDTH, 11'd4, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, rtyuv_pkg::REG_MODE, 11'(rtyuv_pkg::MODE_422), 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd255, 8'd0, 8'd0, 1'b1, 1'b1,
          '{8'd76, 1'b0, 8'sd0, 8'sd0}},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b1,
          '{8'd76, 1'b1, -8'sd37, 8'sd127}},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd10, 8'd200, 8'd30, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd220, 8'd40, 8'd90, 1'b0, 1'b0, NONE},
        // 420: even row fills the line store, odd row reads it
        '{ROW_WRITE, rtyuv_pkg::REG_MODE, 11'(rtyuv_pkg::MODE_420), 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd128, 8'd64, 8'd32, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd1, 8'd2, 8'd3, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd255, 8'd0, 8'd255, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, NONE},
        // unused mode code, odd width
        '{ROW_WRITE, rtyuv_pkg::REG_MODE, 11'(MODE_UNUSED), 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, NONE},
        '{ROW_WRITE, rtyuv_pkg::REG_WIDTH, 11'd7, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd50, 8'd60, 8'd70, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd80, 8'd90, 8'd100, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd5, 8'd250, 8'd5, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd250, 8'd5, 8'd250, 1'b0, 1'b0, NONE},
        // width cut below the current column, zero clamps to 2
        '{ROW_WRITE, rtyuv_pkg::REG_WIDTH, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd9, 8'd9, 8'd9, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd100, 8'd100, 8'd100, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd200, 8'd200, 8'd200, 1'b0, 1'b0, NONE},
        // all-ones width clamps to the maximum
        '{ROW_WRITE, rtyuv_pkg::REG_WIDTH, 11'h7FF, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, rtyuv_pkg::REG_MODE, 11'(rtyuv_pkg::MODE_444), 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, NONE},
        '{ROW_PIXEL, rtyuv_pkg::REG_MODE, 11'd0, 8'd17, 8'd34, 8'd51, 1'b0, 1'b0, NONE}
    };

    // DUT ports
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_valid        = 1'b0;
    logic                          o_ready;
    logic [7:0]                    i_red          = '0;
    logic [7:0]                    i_green        = '0;
    logic [7:0]                    i_blue         = '0;
    logic                          i_frame_start  = 1'b0;
    logic                          o_valid;
    logic                          i_ready        = 1'b1;
    logic [7:0]                    o_luma;
    logic                          o_chroma_valid;
    logic signed [7:0]             o_u_chroma;
    logic signed [7:0]             o_v_chroma;
    logic                          i_cfg_valid    = 1'b0;
    logic                          o_cfg_ready;
    logic                          i_cfg_index    = 1'b0;
    logic [rtyuv_pkg::WIDTH_W-1:0] i_cfg_data     = '0;

    // Converter state as the bench sees it
    logic [1:0]                    cfg_mode   = rtyuv_pkg::MODE_444;
    logic [rtyuv_pkg::WIDTH_W-1:0] cfg_width  = rtyuv_pkg::WIDTH_W'(rtyuv_pkg::MAX_WIDTH);
    int                            px_col     = 0;
    logic                          px_row_odd = 1'b0;
    logic [7:0]                    held_r     = '0;
    logic [7:0]                    held_g     = '0;
    logic [7:0]                    held_b     = '0;
    logic [8:0]                    pair_r [rtyuv_pkg::LINE_DEPTH];
    logic [8:0]                    pair_g [rtyuv_pkg::LINE_DEPTH];
    logic [8:0]                    pair_b [rtyuv_pkg::LINE_DEPTH];
    logic                          pair_written [rtyuv_pkg::LINE_DEPTH];

    t_yuv pending_yuv [$];
    t_yuv head_yuv;

    logic calm       = 1'b0;
    int   stall_left = 0;
    int   n_pixels   = 0;
    int   n_writes   = 0;
    int   n_results  = 0;
    int   n_chroma   = 0;
    int   n_errors   = 0;

    rgb_to_yuv_subsampler u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_frame_start  (i_frame_start),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_luma         (o_luma),
        .o_chroma_valid (o_chroma_valid),
        .o_u_chroma     (o_u_chroma),
        .o_v_chroma     (o_v_chroma),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Weighted group sum, scaled down with truncation toward zero, clipped to int8
    function automatic logic signed [7:0] weigh_chroma(input int kr, input int kg,
                                                       input int kb, input int sr,
                                                       input int sg, input int sb,
                                                       input int shift);
        longint acc;
        longint mag;
        acc = longint'(kr) * sr + longint'(kg) * sg + longint'(kb) * sb;
        mag = (acc < 0) ? -acc : acc;
        mag = mag >> shift;
        if (acc < 0)
            return (mag > 128) ? -8'sd128 : 8'(-mag);
        return (mag > 127) ? 8'sd127 : 8'(mag);
    endfunction

    // One pixel through the converter: returns its beat and advances the state
    function automatic t_yuv convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic fs);
        t_yuv res;
        int   line_len;
        int   luma;
        int   slot;
        int   pr, pg, pb;
        int   sr, sg, sb;
        int   shift;
        logic has_chroma;
        res        = '0;
        has_chroma = 1'b0;
        sr = 0; sg = 0; sb = 0;
        shift = 15;
        line_len = int'({cfg_width[rtyuv_pkg::WIDTH_W-1:1], 1'b0});
        if (line_len < 2)
            line_len = 2;
        if (line_len > rtyuv_pkg::MAX_WIDTH)
            line_len = rtyuv_pkg::MAX_WIDTH;
        if (fs) begin
            px_col     = 0;
            px_row_odd = 1'b0;
        end
        luma = (LUMA_R * int'(r) + LUMA_G * int'(g) + LUMA_B * int'(b)) >> 15;
        res.luma = (luma > 255) ? 8'd255 : 8'(luma);

        if (cfg_mode == rtyuv_pkg::MODE_444) begin
            has_chroma = 1'b1;
            sr = int'(r); sg = int'(g); sb = int'(b);
        end else if (px_col % 2 == 0) begin
            held_r = r; held_g = g; held_b = b;
        end else begin
            pr   = int'(r) + int'(held_r);
            pg   = int'(g) + int'(held_g);
            pb   = int'(b) + int'(held_b);
            slot = (px_col / 2) % rtyuv_pkg::LINE_DEPTH;
            if (cfg_mode == rtyuv_pkg::MODE_422) begin
                has_chroma = 1'b1;
                sr = pr; sg = pg; sb = pb;
                shift = 16;
            end else if (!px_row_odd) begin
                // even row of a 2x2 block: park the pair sum
                pair_r[slot]       = 9'(pr);
                pair_g[slot]       = 9'(pg);
                pair_b[slot]       = 9'(pb);
                pair_written[slot] = 1'b1;
            end else begin
                has_chroma = 1'b1;
                sr = pr + int'(pair_r[slot]);
                sg = pg + int'(pair_g[slot]);
                sb = pb + int'(pair_b[slot]);
                shift = 17;
            end
        end

        if (has_chroma) begin
            res.chroma_valid = 1'b1;
            res.u = weigh_chroma(U_R, U_G, U_B, sr, sg, sb, shift);
            res.v = weigh_chroma(V_R, V_G, V_B, sr, sg, sb, shift);
        end

        px_col++;
        if (px_col >= line_len) begin
            px_col     = 0;
            px_row_odd = ~px_row_odd;
        end
        return res;
    endfunction

    // Present one pixel, wait until it is accepted, record what should come out
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic fs,
                              input logic typed, input t_yuv want);
        t_yuv got;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_ready);
        got = convert_pixel(r, g, b, fs);
        pending_yuv.push_back(typed ? want : got);
        n_pixels++;
    endtask

    // Register write, only once the pipeline has drained
    task automatic write_register(input logic idx,
                                  input logic [rtyuv_pkg::WIDTH_W-1:0] data);
        i_valid <= 1'b0;
        while (pending_yuv.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == rtyuv_pkg::REG_MODE)
            cfg_mode = data[1:0];
        else
            cfg_width = data;
        n_writes++;
    endtask

    // Output side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 11);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_yuv.size() == 0) begin
                $error("result beat with nothing expected: luma %0d", o_luma);
                n_errors++;
            end else begin
                head_yuv = pending_yuv.pop_front();
                n_results++;
                if (head_yuv.chroma_valid)
                    n_chroma++;
                if (o_luma !== head_yuv.luma) begin
                    $error("luma: expected %0d, got %0d", head_yuv.luma, o_luma);
                    n_errors++;
                end
                if (o_chroma_valid !== head_yuv.chroma_valid) begin
                    $error("chroma_valid: expected %0d, got %0d",
                           head_yuv.chroma_valid, o_chroma_valid);
                    n_errors++;
                end
                if (o_u_chroma !== head_yuv.u) begin
                    $error("u_chroma: expected %0d, got %0d",
                           $signed(head_yuv.u), $signed(o_u_chroma));
                    n_errors++;
                end
                if (o_v_chroma !== head_yuv.v) begin
                    $error("v_chroma: expected %0d, got %0d",
                           $signed(head_yuv.v), $signed(o_v_chroma));
                    n_errors++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        int                            n_random;
        int                            burst;
        int                            k;
        logic                          fs;
        logic [rtyuv_pkg::WIDTH_W-1:0] new_width;
        n_random = 0;
        foreach (pair_written[i])
            pair_written[i] = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int row = 0; row < PLAN_ROWS; row++) begin
            if (PLAN[row].kind == ROW_WRITE)
                write_register(PLAN[row].reg_idx, PLAN[row].reg_data);
            else
                send_pixel(PLAN[row].red, PLAN[row].green, PLAN[row].blue,
                           PLAN[row].frame_start, PLAN[row].typed, PLAN[row].want);
        end

        // random phases: new mode and width, then a run of pixels
        while (n_random < RANDOM_PIXELS) begin
            calm = (RANDOM_PIXELS - n_random <= QUIET_TAIL) || ($urandom_range(0, 3) == 0);
            write_register(rtyuv_pkg::REG_MODE,
                           rtyuv_pkg::WIDTH_W'($urandom_range(0, 3)));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    new_width = rtyuv_pkg::WIDTH_W'(2 * $urandom_range(1, 8));
                6:  new_width = rtyuv_pkg::WIDTH_W'(2 * $urandom_range(0, 8) + 1);
                7:  new_width = rtyuv_pkg::WIDTH_W'($urandom_range(0, 2047));
                8:  new_width = rtyuv_pkg::WIDTH_W'(rtyuv_pkg::MAX_WIDTH);
                default:
                    new_width = $urandom_range(0, 1) ? '1 : '0;
            endcase
            write_register(rtyuv_pkg::REG_WIDTH, new_width);

            burst = $urandom_range(8, 48);
            for (k = 0; k < burst && n_random < RANDOM_PIXELS; k++) begin
                fs = (k == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 49) == 0);
                // never let an odd 420 row read a line store entry not yet filled
                if (cfg_mode != rtyuv_pkg::MODE_444 && cfg_mode != rtyuv_pkg::MODE_422
                    && px_col % 2 == 1 && px_row_odd
                    && !pair_written[(px_col / 2) % rtyuv_pkg::LINE_DEPTH])
                    fs = 1'b1;
                send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), fs, 1'b0, NONE);
                n_random++;
            end
        end

        // drain
        i_valid <= 1'b0;
        while (pending_yuv.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d pixels over all modes and widths, %0d register writes",
                 n_pixels, n_writes);
        $display("tb: %0d result beats checked, %0d with chroma, %0d mismatches",
                 n_results, n_chroma, n_errors);
        if (n_errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("tb: FAIL");
        $finish;
    end

endmodule
